@@ hdl/temh_pkg.sv @@
package temh_pkg;

    localparam int HeapDepth = 256;
    localparam int AddrW     = $clog2(HeapDepth);
    localparam int CountW    = AddrW + 1;
    localparam int KeyW      = 48;
    localparam int PayW      = 32;
    localparam int EntryW    = KeyW + PayW;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

@@ hdl/timed_entry_min_heap_top.sv @@
// Timer queue held as a binary min-heap of up to 256 entries in one RAM with a
// single write and a single registered read port. Each transaction is worked
// by a small sequencer that issues at most one RAM read or write per cycle and
// uses one shared 48-bit key comparator. Insert climbs the heap level by level,
// reading and comparing each parent, then writes the entry and gives the result;
// pop reads the root, the last entry and the hole, then descends level by level;
// remove first scans the held entries one slot at a time, then sifts like a pop.
// The block takes no transaction while one is in progress; the result is held
// in an output register so the next transaction may be accepted while it waits.
module timed_entry_min_heap_top
    import temh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] time_sec,
    input  logic [9:0]  time_ms,
    input  logic [15:0] handle,
    input  logic [15:0] object_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] out_handle,
    output logic [15:0] out_object,
    output logic [31:0] out_sec,
    output logic [9:0]  out_ms,
    output logic [8:0]  entry_count
);

    // One-hot sequencer. The R states issue a read; the following state sees data.
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_IPAR  = 14'b00000000000010, // insert: read parent
        S_IPCK  = 14'b00000000000100, // insert: compare parent
        S_SCAN  = 14'b00000000001000, // remove: read slot i; pop: read root
        S_SCK   = 14'b00000000010000, // remove: check slot i; pop: check root
        S_TAKE  = 14'b00000000100000, // read last entry
        S_TCUR  = 14'b00000001000000, // read hole entry
        S_TDIR  = 14'b00000010000000, // choose up or down
        S_DL    = 14'b00000100000000, // down: read left child
        S_DR    = 14'b00001000000000, // down: read right child
        S_DCK   = 14'b00010000000000, // down: pick the smaller child
        S_DMV   = 14'b00100000000000, // down: compare with the smaller child
        S_PUT   = 14'b01000000000000, // write the moving entry at the hole
        S_RES   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CountW-1:0] fill_reg, fill_next;
    logic [8:0]        cap_reg;
    logic [1:0]        op_reg, op_next;
    logic [KeyW-1:0]   key_reg, key_next;   // moving or search key
    logic [PayW-1:0]   pay_reg, pay_next;
    logic [CountW:0]   pos_reg, pos_next;   // 1-based position (0-based slot in a remove scan), room for 2p
    logic [KeyW-1:0]   lkey_reg, lkey_next;
    logic [PayW-1:0]   lpay_reg, lpay_next;
    logic              rsel_reg, rsel_next; // smaller child is the right one
    logic              res_valid_reg;
    logic [1:0]        st_reg, st_next;
    logic [EntryW-1:0] res_ent_reg, res_ent_next;
    logic [1:0]        out_st_reg;
    logic [EntryW-1:0] out_ent_reg;
    logic [CountW-1:0] out_cnt_reg;
    logic              set_res;

    logic              we;
    logic [AddrW-1:0]  waddr, raddr;
    logic [EntryW-1:0] wdata, rdata;
    logic [KeyW-1:0]   rkey;
    logic [PayW-1:0]   rpay;
    logic [CountW-1:0] limit;
    logic [CountW:0]   child;
    logic [KeyW-1:0]   cmp_a, cmp_b;
    logic              a_gt_b;

    temh_ram #(.Width(EntryW), .Depth(HeapDepth)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rkey = rdata[EntryW-1:PayW];
    assign rpay = rdata[PayW-1:0];
    assign limit = (cap_reg > 9'(HeapDepth)) ? CountW'(HeapDepth) : CountW'(cap_reg);
    assign child = {pos_reg[CountW-1:0], 1'b0};
    // The single shared comparator.
    assign a_gt_b = cmp_a > cmp_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            cap_reg       <= 9'd256;
            res_valid_reg <= 1'b0;
            out_st_reg    <= '0;
            out_ent_reg   <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (set_res)
            begin
                res_valid_reg <= 1'b1;
                out_st_reg    <= st_reg;
                out_ent_reg   <= res_ent_reg;
                out_cnt_reg   <= fill_reg;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        pos_reg     <= pos_next;
        lkey_reg    <= lkey_next;
        lpay_reg    <= lpay_next;
        rsel_reg    <= rsel_next;
        st_reg      <= st_next;
        res_ent_reg <= res_ent_next;
    end

    // A new transaction is taken only when the sequencer is idle; a finished
    // result that cannot yet move out holds the sequencer in its result state.
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        pos_next     = pos_reg;
        lkey_next    = lkey_reg;
        lpay_next    = lpay_reg;
        rsel_next    = rsel_reg;
        st_next      = st_reg;
        res_ent_next = res_ent_reg;
        set_res      = 1'b0;
        we           = 1'b0;
        waddr        = AddrW'(pos_reg - 1'b1);
        wdata        = {key_reg, pay_reg};
        raddr        = '0;
        cmp_a        = rkey;
        cmp_b        = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op;
                    key_next     = {time_sec, 6'd0, time_ms};
                    pay_next     = {object_index, handle};
                    res_ent_next = '0;
                    st_next      = ST_EMPTY;
                    if (op == OP_INSERT)
                    begin
                        if (fill_reg >= limit)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_RES;
                        end
                        else
                        begin
                            st_next    = ST_DONE;
                            fill_next  = fill_reg + 1'b1;
                            pos_next   = (CountW+1)'(fill_reg) + 1'b1;
                            state_next = S_IPAR;
                        end
                    end
                    else if (op == OP_REMOVE)
                    begin
                        st_next    = ST_NOTFOUND;
                        pos_next   = '0;
                        state_next = (fill_reg == '0) ? S_RES : S_SCAN;
                    end
                    else if (op == OP_POP)
                    begin
                        pos_next   = (CountW+1)'(1);
                        state_next = (fill_reg == '0) ? S_RES : S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RES;
                    end
                end
            end
            S_IPAR:
            begin
                if (pos_reg == (CountW+1)'(1))
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    raddr      = AddrW'((pos_reg >> 1) - 1'b1);
                    state_next = S_IPCK;
                end
            end
            S_IPCK:
            begin
                if (a_gt_b)
                begin
                    we         = 1'b1;
                    wdata      = rdata;
                    pos_next   = pos_reg >> 1;
                    state_next = S_IPAR;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_SCAN:
            begin
                // For remove pos_reg is a 0-based slot; for pop it is the root.
                raddr      = (op_reg == OP_REMOVE) ? AddrW'(pos_reg) : '0;
                state_next = S_SCK;
            end
            S_SCK:
            begin
                if (op_reg == OP_REMOVE)
                begin
                    if (rpay == pay_reg)
                    begin
                        st_next    = ST_DONE;
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_TAKE;
                    end
                    else if (pos_reg + 1'b1 >= (CountW+1)'(fill_reg))
                    begin
                        state_next = S_RES;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    cmp_a = rkey;
                    cmp_b = key_reg;
                    if (a_gt_b)
                    begin
                        state_next = S_RES;
                    end
                    else
                    begin
                        st_next      = ST_DONE;
                        res_ent_next = rdata;
                        state_next   = S_TAKE;
                    end
                end
            end
            S_TAKE:
            begin
                raddr      = AddrW'(fill_reg - 1'b1);
                state_next = S_TCUR;
            end
            S_TCUR:
            begin
                lkey_next  = rkey;
                lpay_next  = rpay;
                raddr      = AddrW'(pos_reg - 1'b1);
                state_next = S_TDIR;
            end
            S_TDIR:
            begin
                // Moving entry is the last one; it goes up only if below the hole.
                key_next  = lkey_reg;
                pay_next  = lpay_reg;
                fill_next = fill_reg - 1'b1;
                cmp_a     = rkey;
                cmp_b     = lkey_reg;
                state_next = a_gt_b ? S_IPAR : S_DL;
            end
            S_DL:
            begin
                // Children are searched below the old count, before the decrement.
                if (child >= (CountW+1)'(fill_reg) + 1'b1)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    raddr      = AddrW'(child - 1'b1);
                    state_next = S_DR;
                end
            end
            S_DR:
            begin
                lkey_next  = rkey;
                lpay_next  = rpay;
                raddr      = AddrW'(child);
                state_next = S_DCK;
            end
            S_DCK:
            begin
                // Right child exists at index child+1 if it is below old count.
                cmp_a     = lkey_reg;
                cmp_b     = rkey;
                rsel_next = 1'b0;
                if (child + 1'b1 < (CountW+1)'(fill_reg) + 1'b1 && a_gt_b)
                begin
                    lkey_next = rkey;
                    lpay_next = rpay;
                    rsel_next = 1'b1;
                end
                state_next = S_DMV;
            end
            S_DMV:
            begin
                // The moving entry stops unless it is above the smaller child.
                cmp_a = key_reg;
                cmp_b = lkey_reg;
                if (a_gt_b)
                begin
                    we         = 1'b1;
                    wdata      = {lkey_reg, lpay_reg};
                    pos_next   = child + (CountW+1)'(rsel_reg);
                    state_next = S_DL;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                we         = 1'b1;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!res_valid_reg || out_ready)
                begin
                    set_res    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = res_valid_reg;
    assign status      = out_st_reg;
    assign out_handle  = out_ent_reg[15:0];
    assign out_object  = out_ent_reg[31:16];
    assign out_sec     = out_ent_reg[EntryW-1:EntryW-32];
    assign out_ms      = out_ent_reg[PayW+9:PayW];
    assign entry_count = out_cnt_reg;

endmodule

@@ hdl/temh_ram.sv @@
module temh_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ tb/tb_timed_entry_min_heap_top.sv @@
module tb_timed_entry_min_heap_top;
    import temh_pkg::*;

    // One pending result of the timer queue, as the block should present it.
    typedef struct {
        logic [1:0]  status;
        logic [15:0] hnd;
        logic [15:0] obj;
        logic [31:0] sec;
        logic [9:0]  ms;
        logic [8:0]  count;
    } heap_result_t;

    // One row of the directed table. When has_result is set the expected
    // result is typed in and checked against the predictor's answer as well.
    typedef struct {
        logic [1:0]  op;
        logic [31:0] sec;
        logic [9:0]  ms;
        logic [15:0] hnd;
        logic [15:0] obj;
        bit          has_result;
        logic [1:0]  status;
        logic [8:0]  count;
    } stim_row_t;

    localparam int WatchdogLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [31:0] time_sec;
    logic [9:0]  time_ms;
    logic [15:0] handle;
    logic [15:0] object_index;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [15:0] out_object;
    logic [31:0] out_sec;
    logic [9:0]  out_ms;
    logic [8:0]  entry_count;

    // The predictor's own copy of the heap, kept with 1-based positions.
    logic [47:0] mdl_keys [1:HeapDepth];
    logic [31:0] mdl_pays [1:HeapDepth];
    int          mdl_fill;
    int          mdl_limit;

    heap_result_t pending_results[$];
    int  mismatch_count;
    int  idle_cycles;
    bit  hold_off_req;
    bit  quiet_phase;

    timed_entry_min_heap_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .time_sec     (time_sec),
        .time_ms      (time_ms),
        .handle       (handle),
        .object_index (object_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_handle   (out_handle),
        .out_object   (out_object),
        .out_sec      (out_sec),
        .out_ms       (out_ms),
        .entry_count  (entry_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Removes the entry at position p by moving the last entry into the hole
    // and letting it sift up or down, as the hardware does.
    function automatic void heap_take_out(int p);
        int          n;
        int          j;
        logic [47:0] t;
        logic [31:0] tp;
        n  = mdl_fill;
        t  = mdl_keys[n];
        tp = mdl_pays[n];
        if (t < mdl_keys[p])
        begin
            while (p > 1 && mdl_keys[p / 2] > t)
            begin
                mdl_keys[p] = mdl_keys[p / 2];
                mdl_pays[p] = mdl_pays[p / 2];
                p = p / 2;
            end
        end
        else
        begin
            j = p * 2;
            while (j < n)
            begin
                if (mdl_keys[j] > mdl_keys[j + 1])
                    j++;
                if (t <= mdl_keys[j])
                    break;
                mdl_keys[p] = mdl_keys[j];
                mdl_pays[p] = mdl_pays[j];
                p = j;
                j = j * 2;
            end
        end
        mdl_keys[p] = t;
        mdl_pays[p] = tp;
        mdl_fill = n - 1;
    endfunction

    // Works out the result of one transaction and updates the predicted heap.
    function automatic heap_result_t predict_heap_op(logic [1:0] code, logic [31:0] sec,
                                                     logic [9:0] ms, logic [15:0] hnd,
                                                     logic [15:0] obj);
        heap_result_t r;
        logic [47:0]  key;
        logic [31:0]  pay;
        int           lim;
        int           p;
        key = {sec, 6'd0, ms};
        pay = {obj, hnd};
        r   = '{ST_EMPTY, '0, '0, '0, '0, '0};
        lim = (mdl_limit > HeapDepth) ? HeapDepth : mdl_limit;
        case (code)
            OP_INSERT:
            begin
                if (mdl_fill >= lim)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    mdl_fill++;
                    p = mdl_fill;
                    while (p > 1 && mdl_keys[p / 2] > key)
                    begin
                        mdl_keys[p] = mdl_keys[p / 2];
                        mdl_pays[p] = mdl_pays[p / 2];
                        p = p / 2;
                    end
                    mdl_keys[p] = key;
                    mdl_pays[p] = pay;
                    r.status = ST_DONE;
                end
            end
            OP_REMOVE:
            begin
                r.status = ST_NOTFOUND;
                for (int i = 1; i <= mdl_fill; i++)
                begin
                    if (mdl_pays[i] == pay)
                    begin
                        heap_take_out(i);
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            OP_POP:
            begin
                if (mdl_fill != 0 && mdl_keys[1] <= key)
                begin
                    r.hnd    = mdl_pays[1][15:0];
                    r.obj    = mdl_pays[1][31:16];
                    r.sec    = mdl_keys[1][47:16];
                    r.ms     = mdl_keys[1][9:0];
                    heap_take_out(1);
                    r.status = ST_DONE;
                end
            end
            default:
            begin
            end
        endcase
        r.count = mdl_fill[8:0];
        return r;
    endfunction

    // Presents one transaction and waits for its acceptance. The predictor is
    // run at the accepting edge so that expectations stay in order.
    task automatic send_item(logic [1:0] code, logic [31:0] sec, logic [9:0] ms,
                             logic [15:0] hnd, logic [15:0] obj,
                             bit has_result, logic [1:0] st, logic [8:0] cnt);
        heap_result_t r;
        in_valid     <= 1'b1;
        op           <= code;
        time_sec     <= sec;
        time_ms      <= ms;
        handle       <= hnd;
        object_index <= obj;
        do
            @(posedge clk);
        while (!in_ready);
        r = predict_heap_op(code, sec, ms, hnd, obj);
        if (has_result && (r.status !== st || r.count !== cnt))
            $display("Directed row disagrees with predictor: op %0d status %0d count %0d",
                     code, r.status, r.count);
        if (has_result)
        begin
            r.status = st;
            r.count  = cnt;
        end
        pending_results.push_back(r);
    endtask

    // Drops valid for a random burst now and then, except in the quiet phase.
    task automatic sender_gap();
        int n;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 4);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_random(logic [1:0] code, int sec_span);
        send_item(code, $urandom_range(0, sec_span), $urandom_range(0, 999),
                  $urandom_range(0, 7), $urandom_range(0, 7), 1'b0, '0, '0);
        sender_gap();
    endtask

    // Waits until every expectation has been met, then lets the block settle
    // for the longest a single transaction can take.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_capacity(logic [8:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mdl_limit = value;
    endtask

    // The receiver: random stall bursts, plus a long hold-off on request so
    // that the block backs up and refuses input.
    initial
    begin
        int n;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 4);
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Result checker: each accepted result is compared with the oldest one
    // expected.
    always @(posedge clk)
    begin
        heap_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: status %0d count %0d", status, entry_count);
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status || out_handle !== e.hnd || out_object !== e.obj ||
                    out_sec !== e.sec || out_ms !== e.ms || entry_count !== e.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Result mismatch: expected st %0d h %h o %h s %h ms %0d n %0d",
                                 e.status, e.hnd, e.obj, e.sec, e.ms, e.count);
                        $display("                 got      st %0d h %h o %h s %h ms %0d n %0d",
                                 status, out_handle, out_object, out_sec, out_ms,
                                 entry_count);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        op             = OP_INSERT;
        time_sec       = '0;
        time_ms        = '0;
        handle         = '0;
        object_index   = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        hold_off_req   = 1'b0;
        quiet_phase    = 1'b0;
        mdl_fill       = 0;
        mdl_limit      = 256;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty-heap cases, field extremes, equal keys,
        // duplicate payloads, milliseconds above 999 and the unused op code.
        rows = '{
            '{OP_POP,    32'hFFFF_FFFF, 10'h3FF, 16'h0, 16'h0, 1, ST_EMPTY, 9'd0},
            '{OP_REMOVE, 32'h0, 10'h0, 16'h0, 16'h0, 1, ST_NOTFOUND, 9'd0},
            '{OP_UNUSED, 32'h0, 10'h0, 16'h0, 16'h0, 1, ST_EMPTY, 9'd0},
            '{OP_INSERT, 32'hFFFF_FFFF, 10'h3FF, 16'hFFFF, 16'hFFFF, 1, ST_DONE, 9'd1},
            '{OP_INSERT, 32'h0, 10'h0, 16'h0, 16'h0, 1, ST_DONE, 9'd2},
            '{OP_INSERT, 32'd100, 10'd500, 16'h1234, 16'h5678, 0, 0, 0},
            '{OP_INSERT, 32'd100, 10'd500, 16'h1234, 16'h5678, 0, 0, 0},
            '{OP_INSERT, 32'd100, 10'd500, 16'hAAAA, 16'h5555, 0, 0, 0},
            '{OP_INSERT, 32'd50, 10'd1000, 16'h5555, 16'hAAAA, 0, 0, 0},
            '{OP_POP,    32'h0, 10'h0, 16'h0, 16'h0, 0, 0, 0},
            '{OP_POP,    32'd50, 10'd999, 16'h0, 16'h0, 0, 0, 0},
            '{OP_POP,    32'd50, 10'd1000, 16'h0, 16'h0, 0, 0, 0},
            '{OP_REMOVE, 32'h0, 10'h0, 16'h1234, 16'h5678, 0, 0, 0},
            '{OP_REMOVE, 32'h0, 10'h0, 16'h1234, 16'h5679, 0, 0, 0},
            '{OP_POP,    32'd100, 10'd500, 16'h0, 16'h0, 0, 0, 0},
            '{OP_REMOVE, 32'h0, 10'h0, 16'hFFFF, 16'hFFFF, 0, 0, 0},
            '{OP_POP,    32'hFFFF_FFFF, 10'h3FF, 16'h0, 16'h0, 0, 0, 0},
            '{OP_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 16'hFFFF, 16'hFFFF, 0, 0, 0}
        };
        foreach (rows[i])
        begin
            send_item(rows[i].op, rows[i].sec, rows[i].ms, rows[i].hnd, rows[i].obj,
                      rows[i].has_result, rows[i].status, rows[i].count);
            sender_gap();
        end
        drain_results();

        // A capacity of zero refuses every insert.
        write_capacity(9'd0);
        send_item(OP_INSERT, 32'd1, 10'd1, 16'd1, 16'd1, 1'b1, ST_FULL, 9'(mdl_fill));
        drain_results();

        // Small capacity: fill to the limit and beyond with random work.
        write_capacity(9'd1);
        for (int i = 0; i < 60; i++)
            send_random(2'($urandom_range(0, 3)), 20);
        drain_results();
        write_capacity(9'd5);
        for (int i = 0; i < 150; i++)
            send_random($urandom_range(0, 2) == 0 ? OP_POP :
                        2'($urandom_range(0, 1)), 40);
        drain_results();

        // Full depth, and a value above it that is clamped. The long hold-off
        // by the receiver runs while the sender keeps offering inserts.
        write_capacity(9'd511);
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_random(OP_INSERT, 1000);
        for (int i = 0; i < 280; i++)
            send_item(OP_INSERT, $urandom(), $urandom_range(0, 1023), $urandom(), $urandom(),
                      1'b0, '0, '0);
        // Sender pause until everything has come back.
        drain_results();
        for (int i = 0; i < 290; i++)
            send_random($urandom_range(0, 3) == 0 ? OP_REMOVE : OP_POP, 2000);
        for (int i = 0; i < 100; i++)
            send_item(OP_POP, $urandom(), $urandom_range(0, 1023), 16'h0, 16'h0,
                      1'b0, '0, '0);
        drain_results();

        // Ordinary mixed work, with the last stretch free of idling.
        write_capacity(9'd256);
        for (int i = 0; i < 200; i++)
        begin
            if (i == 150)
                quiet_phase = 1'b1;
            send_random(2'($urandom_range(0, 3)), 200);
        end
        drain_results();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/temh_pkg.sv
hdl/temh_ram.sv
hdl/timed_entry_min_heap_top.sv
tb/tb_timed_entry_min_heap_top.sv
